// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Pool geometry, tree node codes and the index helpers shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	localparam int LEVELS     = 6;
	localparam int UNIT_BYTES = 64;
	localparam int UNITS      = 1 << LEVELS;
	localparam int NODES      = 2 * UNITS;
	localparam int POOL_BYTES = UNITS * UNIT_BYTES;

	localparam int UNIT_W = LEVELS;
	localparam int LINK_W = LEVELS + 1;
	localparam int NODE_W = LEVELS + 1;
	localparam int LVL_W  = $clog2(LEVELS + 1);
	localparam int OFF_W  = $clog2(POOL_BYTES);

	localparam int SIZE_W = 16;
	localparam int ADDR_W = 32;

	typedef logic [1:0]        node_st_t;
	typedef logic [LINK_W-1:0] link_t;

	localparam node_st_t NS_UNINIT = 2'd0;
	localparam node_st_t NS_FREE   = 2'd1;
	localparam node_st_t NS_USED   = 2'd2;
	localparam node_st_t NS_SPLIT  = 2'd3;

	// A link with the top bit set ends a list.
	localparam link_t NIL = link_t'(UNITS);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Heap-ordered tree: block i of level l sits at node 2^l - 1 + i.
	function automatic logic [NODE_W-1:0] node_of(input logic [UNIT_W-1:0] unit,
			input logic [LVL_W-1:0] lvl);
		logic [NODE_W-1:0] base;
		logic [NODE_W-1:0] ofs;
		base = (NODE_W'(1) << lvl) - NODE_W'(1);
		ofs  = NODE_W'(unit >> (LVL_W'(LEVELS) - lvl));
		return base + ofs;
	endfunction

	// Size of a block of the given level in units.
	function automatic logic [UNIT_W:0] span_of(input logic [LVL_W-1:0] lvl);
		return (UNIT_W + 1)'(1) << (LVL_W'(LEVELS) - lvl);
	endfunction

	function automatic link_t link_norm(input link_t v);
		return v[UNIT_W] ? NIL : v;
	endfunction

endpackage

`default_nettype wire

// ----- src/bba_req_if.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [bba_pkg::SIZE_W-1:0]  request_size;
	logic [bba_pkg::ADDR_W-1:0]  free_address;

	modport source (output valid, output operation, output request_size,
		output free_address, input ready);
	modport sink (input valid, input operation, input request_size,
		input free_address, output ready);
endinterface

`default_nettype wire

// ----- src/bba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::ADDR_W-1:0]  block_address;
	logic                        result_status;

	modport source (output valid, output block_address, output result_status,
		input ready);
	modport sink (input valid, input block_address, input result_status,
		output ready);
endinterface

`default_nettype wire

// ----- src/bba_ram.sv -----
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- src/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator with per-level free lists and a split/use status tree.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on the req channel (operation 0 allocates
// request_size bytes, operation 1 frees free_address). Each request yields
// exactly one beat on rsp: block_address (pool_base plus offset, zero on
// failure and on every free) and result_status (0 success, 1 failure).
// pool_base is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block does not enforce this. One request
// is worked on at a time; ready is high only between requests. The sequencer
// works around the node tree RAM and the link RAM, both with registered reads:
//   allocate: pick a level, split a block per level down to the target,
//   pop the target list, then the result stage; free: search for the split
//   parent, check the block, then check the buddy at each level, and on a merge
//   walk the list to unlink the buddy and update the tree; then the result stage.
// Reset empties every list but level zero, which holds the whole pool, and
// clears pool_base. A finished result waits in the output register while
// the receiver stalls; the next request is taken meanwhile, and its result
// is held back until the output register has been emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wr_data,
	bba_req_if.sink                         req,
	bba_rsp_if.source                       rsp
);

	localparam int UW = bba_pkg::UNIT_W;
	localparam int LW = bba_pkg::LVL_W;
	localparam int NW = bba_pkg::NODE_W;
	localparam int KW = bba_pkg::LINK_W;
	localparam int OW = bba_pkg::OFF_W;
	localparam int AW = bba_pkg::ADDR_W;

	typedef enum logic [4:0] {
		S_IDLE, S_FIND, S_FINDW, S_CHK, S_CHKW,
		S_MSTART, S_MBUD, S_UHEADW, S_URD, S_UCHK, S_UFIXW,
		S_MCLR1, S_MCLR2, S_MPAR,
		S_ASEL, S_SRD, S_SPOPW, S_SW2, S_SW3, S_APOP, S_APOPW,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             pool_base_q;
	logic [LW-1:0]             lvl_q;
	logic [LW-1:0]             tgt_q;
	logic [UW-1:0]             unit_q;
	bba_pkg::link_t            cur_q;
	logic [KW-1:0]             steps_q;
	bba_pkg::link_t            head_q [bba_pkg::LEVELS+1];
	logic [bba_pkg::NODES-1:0] node_vld_q;
	logic                      link0_wr_q;
	logic                      nrd_vld_s1;
	logic                      nrd_root_s1;
	logic                      lrd_zero_s1;
	logic [AW-1:0]             res_addr_q;
	logic                      res_fail_q;
	logic                      rsp_vld_q;
	logic [AW-1:0]             rsp_addr_q;
	logic                      rsp_st_q;

	// RAM ports
	logic                 node_we;
	logic [NW-1:0]        node_waddr;
	bba_pkg::node_st_t    node_wdata;
	logic [NW-1:0]        node_raddr;
	bba_pkg::node_st_t    node_rdata;
	logic                 lnk_we;
	logic [UW-1:0]        lnk_waddr;
	bba_pkg::link_t       lnk_wdata;
	logic [UW-1:0]        lnk_raddr;
	bba_pkg::link_t       lnk_rdata;

	// Derived values
	logic [UW:0]          span_w;
	logic [UW-1:0]        span;
	logic [UW-1:0]        unit_al;
	logic [UW-1:0]        bud;
	logic [LW-1:0]        lvl_m1;
	logic [LW-1:0]        lvl_p1;
	logic [UW-1:0]        p2;
	logic [NW-1:0]        idx;
	logic [NW-1:0]        bidx;
	bba_pkg::link_t       head_cur;
	bba_pkg::link_t       head_nxt;
	bba_pkg::node_st_t    nrd;
	bba_pkg::link_t       lk;
	logic [LW-1:0]        req_lvl;
	logic                 req_big;
	logic [LW-1:0]        src_lvl;
	logic                 src_ok;
	logic [AW-1:0]        off;
	logic                 off_bad;
	logic [AW-1:0]        blk_addr;
	logic                 bud_at_head;

	bba_ram #(.WIDTH(2), .DEPTH(bba_pkg::NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	bba_ram #(.WIDTH(KW), .DEPTH(bba_pkg::UNITS)) u_link_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	assign span_w   = bba_pkg::span_of(lvl_q);
	assign span     = UW'(span_w);
	assign unit_al  = unit_q & ~UW'(span_w - (UW + 1)'(1));
	assign bud      = unit_q ^ span;
	assign lvl_m1   = lvl_q - LW'(1);
	assign lvl_p1   = lvl_q + LW'(1);
	assign p2       = unit_q | UW'(bba_pkg::span_of(lvl_p1));
	assign idx      = bba_pkg::node_of(unit_q, lvl_q);
	assign bidx     = bba_pkg::node_of(bud, lvl_q);
	assign head_cur = head_q[lvl_q];
	assign head_nxt = head_q[lvl_p1];
	assign bud_at_head = (head_cur == {1'b0, bud});

	// Entries never written read as their reset value.
	assign nrd = nrd_vld_s1 ? node_rdata :
		(nrd_root_s1 ? bba_pkg::NS_FREE : bba_pkg::NS_UNINIT);
	assign lk  = lrd_zero_s1 ? bba_pkg::NIL : bba_pkg::link_norm(lnk_rdata);

	assign off      = req.free_address - pool_base_q;
	assign off_bad  = (off >= AW'(bba_pkg::POOL_BYTES));
	assign blk_addr = pool_base_q + (AW'(unit_q) * AW'(bba_pkg::UNIT_BYTES));

	// Deepest level, i.e. smallest block, that holds the requested byte count.
	always_comb begin
		req_lvl = '0;
		req_big = 1'b1;
		for (int k = bba_pkg::LEVELS; k >= 0; k--) begin
			if ((AW'(bba_pkg::UNIT_BYTES) << k) >= AW'(req.request_size)) begin
				req_lvl = LW'(bba_pkg::LEVELS - k);
				req_big = 1'b0;
			end
		end
	end

	// Nearest shallower level with a free block to split.
	always_comb begin
		src_lvl = '0;
		src_ok  = 1'b0;
		for (int l = 0; l <= bba_pkg::LEVELS; l++) begin
			if (LW'(l) < tgt_q && !head_q[l][UW]) begin
				src_lvl = LW'(l);
				src_ok  = 1'b1;
			end
		end
	end

	always_comb begin
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = bba_pkg::NS_UNINIT;
		node_raddr = '0;
		lnk_we     = 1'b0;
		lnk_waddr  = '0;
		lnk_wdata  = bba_pkg::NIL;
		lnk_raddr  = '0;
		case (state_q)
			S_FIND: begin
				node_raddr = bba_pkg::node_of(unit_q, lvl_m1);
			end
			S_CHK: begin
				node_raddr = bba_pkg::node_of(unit_al, lvl_q);
			end
			S_MSTART: begin
				node_we = 1'b1;
				node_wdata = bba_pkg::NS_FREE;
				if (lvl_q == '0) begin
					node_waddr = '0;
					lnk_we     = 1'b1;
					lnk_waddr  = '0;
					lnk_wdata  = bba_pkg::NIL;
				end else begin
					node_waddr = idx;
					node_raddr = bidx;
				end
			end
			S_MBUD: begin
				if (nrd != bba_pkg::NS_FREE) begin
					lnk_we    = 1'b1;
					lnk_waddr = unit_q;
					lnk_wdata = head_cur;
				end else if (bud_at_head) begin
					lnk_raddr = bud;
				end
			end
			S_URD: begin
				lnk_raddr = cur_q[UW-1:0];
			end
			S_UCHK: begin
				lnk_raddr = bud;
			end
			S_UFIXW: begin
				lnk_we    = 1'b1;
				lnk_waddr = cur_q[UW-1:0];
				lnk_wdata = lk;
			end
			S_MCLR1: begin
				node_we = 1'b1;
				node_waddr = idx;
				node_wdata = bba_pkg::NS_UNINIT;
			end
			S_MCLR2: begin
				node_we = 1'b1;
				node_waddr = bidx;
				node_wdata = bba_pkg::NS_UNINIT;
			end
			S_MPAR: begin
				node_we = 1'b1;
				node_waddr = bba_pkg::node_of(unit_q, lvl_m1);
				node_wdata = bba_pkg::NS_USED;
			end
			S_SRD, S_APOP: begin
				lnk_raddr = head_cur[UW-1:0];
			end
			S_SPOPW: begin
				node_we    = 1'b1;
				node_waddr = idx;
				node_wdata = bba_pkg::NS_SPLIT;
				lnk_we     = 1'b1;
				lnk_waddr  = p2;
				lnk_wdata  = head_nxt;
			end
			S_SW2: begin
				node_we    = 1'b1;
				node_waddr = bba_pkg::node_of(unit_q, lvl_p1);
				node_wdata = bba_pkg::NS_FREE;
				lnk_we     = 1'b1;
				lnk_waddr  = unit_q;
				lnk_wdata  = {1'b0, p2};
			end
			S_SW3: begin
				node_we    = 1'b1;
				node_waddr = bba_pkg::node_of(p2, lvl_p1);
				node_wdata = bba_pkg::NS_FREE;
			end
			S_APOPW: begin
				node_we    = 1'b1;
				node_waddr = idx;
				node_wdata = bba_pkg::NS_USED;
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_vld_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.result_status = rsp_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pool_base_q <= '0;
			steps_q     <= '0;
			node_vld_q  <= '0;
			link0_wr_q  <= 1'b0;
			nrd_vld_s1  <= 1'b0;
			nrd_root_s1 <= 1'b0;
			lrd_zero_s1 <= 1'b0;
			rsp_vld_q   <= 1'b0;
			for (int l = 0; l <= bba_pkg::LEVELS; l++) begin
				head_q[l] <= (l == 0) ? '0 : bba_pkg::NIL;
			end
		end else begin
			if (cfg_wr_en) begin
				pool_base_q <= cfg_wr_data;
			end
			if (node_we) begin
				node_vld_q[node_waddr] <= 1'b1;
			end
			if (lnk_we && lnk_waddr == '0) begin
				link0_wr_q <= 1'b1;
			end
			nrd_vld_s1  <= node_vld_q[node_raddr];
			nrd_root_s1 <= (node_raddr == '0);
			lrd_zero_s1 <= (lnk_raddr == '0) && !link0_wr_q;
			// The result stage reloads the output register itself.
			if (rsp_vld_q && rsp.ready && state_q != S_RESP) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_addr_q <= '0;
						res_fail_q <= 1'b1;
						if (req.operation == bba_pkg::OP_ALLOC) begin
							tgt_q   <= req_lvl;
							state_q <= req_big ? S_RESP : S_ASEL;
						end else begin
							// The unit size is a power of two, so the unit index is
							// the top bits of the offset.
							unit_q  <= off[OW-1 -: UW];
							lvl_q   <= LW'(bba_pkg::LEVELS);
							state_q <= off_bad ? S_RESP : S_FIND;
						end
					end
				end
				S_FIND: begin
					state_q <= (lvl_q == '0) ? S_CHK : S_FINDW;
				end
				S_FINDW: begin
					if (nrd == bba_pkg::NS_SPLIT) begin
						state_q <= S_CHK;
					end else begin
						lvl_q   <= lvl_m1;
						state_q <= S_FIND;
					end
				end
				S_CHK: begin
					unit_q  <= unit_al;
					state_q <= S_CHKW;
				end
				S_CHKW: begin
					state_q <= (nrd != bba_pkg::NS_USED) ? S_RESP : S_MSTART;
				end
				S_MSTART: begin
					if (lvl_q == '0) begin
						head_q[0]  <= '0;
						res_fail_q <= 1'b0;
						state_q    <= S_RESP;
					end else begin
						state_q <= S_MBUD;
					end
				end
				S_MBUD: begin
					if (nrd != bba_pkg::NS_FREE) begin
						head_q[lvl_q] <= {1'b0, unit_q};
						res_fail_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						cur_q   <= head_cur;
						steps_q <= '0;
						state_q <= bud_at_head ? S_UHEADW : S_URD;
					end
				end
				S_UHEADW: begin
					head_q[lvl_q] <= lk;
					state_q       <= S_MCLR1;
				end
				S_URD: begin
					state_q <= cur_q[UW] ? S_MCLR1 : S_UCHK;
				end
				// Walk the list until the entry whose successor is the buddy.
				S_UCHK: begin
					if (lk == {1'b0, bud}) begin
						state_q <= S_UFIXW;
					end else if (steps_q == KW'(bba_pkg::UNITS)) begin
						state_q <= S_MCLR1;
					end else begin
						cur_q   <= lk;
						steps_q <= steps_q + KW'(1);
						state_q <= S_URD;
					end
				end
				S_UFIXW: begin
					state_q <= S_MCLR1;
				end
				S_MCLR1: begin
					state_q <= S_MCLR2;
				end
				S_MCLR2: begin
					state_q <= S_MPAR;
				end
				S_MPAR: begin
					unit_q  <= unit_q & ~span;
					lvl_q   <= lvl_m1;
					state_q <= S_MSTART;
				end
				S_ASEL: begin
					if (!head_q[tgt_q][UW]) begin
						lvl_q   <= tgt_q;
						state_q <= S_APOP;
					end else if (src_ok) begin
						lvl_q   <= src_lvl;
						state_q <= S_SRD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SRD: begin
					unit_q  <= head_cur[UW-1:0];
					state_q <= S_SPOPW;
				end
				S_SPOPW: begin
					head_q[lvl_q] <= lk;
					state_q       <= S_SW2;
				end
				S_SW2: begin
					head_q[lvl_p1] <= {1'b0, unit_q};
					state_q        <= S_SW3;
				end
				S_SW3: begin
					lvl_q   <= lvl_p1;
					state_q <= (lvl_p1 == tgt_q) ? S_APOP : S_SRD;
				end
				S_APOP: begin
					if (head_cur[UW]) begin
						state_q <= S_RESP;
					end else begin
						unit_q  <= head_cur[UW-1:0];
						state_q <= S_APOPW;
					end
				end
				S_APOPW: begin
					head_q[lvl_q] <= lk;
					res_addr_q    <= blk_addr;
					res_fail_q    <= 1'b0;
					state_q       <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q  <= 1'b1;
						rsp_addr_q <= res_addr_q;
						rsp_st_q   <= res_fail_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!node_we && !lnk_we))
		else $error("memory written while idle");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in progress");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= KW'(bba_pkg::UNITS))
		else $error("free list walk exceeded the pool size");

	a_link_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(lnk_we && lnk_wdata[UW]) |-> (lnk_wdata == bba_pkg::NIL))
		else $error("malformed end-of-list link written");
`endif

endmodule

`default_nettype wire
